### src/a85d_pkg.sv
// ----------------------------------------------------------------------------
// a85d_pkg - shared constants and tables for the ASCII85 decoder
// Holds the digit bias, the base-85 position weights and the padding sums
// used when a stream ends inside a group.
// ----------------------------------------------------------------------------
package a85d_pkg;

    localparam int unsigned GROUP_DIGITS = 5;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned COUNT_W      = 3;
    localparam int unsigned DIGIT_W      = 9;

    localparam logic [DIGIT_W-1:0] DIGIT_BIAS = 9'd33;

    typedef logic [COUNT_W-1:0] digit_count_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [BYTE_W-1:0]  byte_t;

    // Weight of a digit position, most significant position first.
    function automatic word_t digit_weight(input digit_count_t pos);
        word_t w;
        unique case (pos)
            3'd0:    w = 32'd52200625;
            3'd1:    w = 32'd614125;
            3'd2:    w = 32'd7225;
            3'd3:    w = 32'd85;
            default: w = 32'd1;
        endcase
        return w;
    endfunction

    // Sum of 117 times the weight of every position missing when a stream
    // ends after n digits. A full group takes no padding.
    function automatic word_t pad_sum(input digit_count_t n);
        word_t p;
        unique case (n)
            3'd1:    p = 32'd72708012;
            3'd2:    p = 32'd855387;
            3'd3:    p = 32'd10062;
            3'd4:    p = 32'd117;
            default: p = 32'd0;
        endcase
        return p;
    endfunction

endpackage

### src/a85d_if.sv
// ----------------------------------------------------------------------------
// a85d_if - stream channels of the ASCII85 decoder
// One channel carries text characters in, the other decoded bytes out.
// ----------------------------------------------------------------------------
interface a85d_char_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           char_code;
    logic                 final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

interface a85d_byte_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           out_byte;
    logic                 run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

### src/ascii85_decoder.sv
// ----------------------------------------------------------------------------
// ascii85_decoder - streaming ASCII85 text to binary decoder
// Accepts one character and emits one decoded byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// Path: the character completing a group passes the input register, the
// accumulate stage and the queue write before its first byte is valid.
// Throughput: one character per cycle while ready is high; the output side
// drains one byte per cycle; the group queue fills only on consumer stalls.
// Reset: rst_n clears the accumulator, the digit count, the pipeline valids
// and the queue pointers at once; no clearing pass is needed.
module ascii85_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    a85d_char_if.sink   char_chan,
    a85d_byte_if.source byte_chan
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned OCC_W = CNT_W + 1;

    // ------------------------------------------------------------------------
    // Stage 1: input register. A transaction on the character channel is
    // captured here unconditionally; back pressure is handled by ready.
    // ------------------------------------------------------------------------
    logic                                in_valid_reg;
    logic [7:0]                          in_code_reg;
    logic                                in_final_reg;
    logic                                char_take;

    assign char_take = char_chan.valid && char_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= char_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_take)
        begin
            in_code_reg  <= char_chan.char_code;
            in_final_reg <= char_chan.final_char;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: accumulate. The digit is code minus 33 as a signed 9-bit value;
    // sign extension to 32 bits gives the same wrap as unsigned arithmetic
    // modulo 2^32. The weighted digit is added into the group sum.
    // ------------------------------------------------------------------------
    a85d_pkg::word_t        group_value_reg;
    a85d_pkg::word_t        group_value_next;
    a85d_pkg::digit_count_t digit_count_reg;
    a85d_pkg::digit_count_t digit_count_next;

    logic signed [a85d_pkg::DIGIT_W-1:0] digit;
    a85d_pkg::word_t                     digit_ext;
    a85d_pkg::word_t                     weighted;
    a85d_pkg::word_t                     sum;
    a85d_pkg::digit_count_t              taken;
    logic                                group_full;
    logic                                emit;

    // Group word waiting to receive its padding and enter the queue.
    logic                   emit_valid_reg;
    logic                   emit_valid_next;
    a85d_pkg::word_t        emit_sum_reg;
    a85d_pkg::word_t        emit_pad_reg;
    logic [1:0]             emit_last_reg;

    always_comb
    begin
        digit      = $signed({1'b0, in_code_reg}) - $signed(a85d_pkg::DIGIT_BIAS);
        digit_ext  = {{(a85d_pkg::WORD_W - a85d_pkg::DIGIT_W){digit[a85d_pkg::DIGIT_W-1]}},
                      digit};
        weighted   = digit_ext * a85d_pkg::digit_weight(digit_count_reg);
        sum        = group_value_reg + weighted;
        taken      = digit_count_reg + 3'd1;
        group_full = (taken == 3'(a85d_pkg::GROUP_DIGITS));
        // A final character after a single digit leaves nothing to emit.
        emit       = in_valid_reg && (group_full || (in_final_reg && (taken >= 3'd2)));
    end

    always_comb
    begin
        group_value_next = group_value_reg;
        digit_count_next = digit_count_reg;
        emit_valid_next  = emit;
        if (in_valid_reg)
        begin
            if (group_full || in_final_reg)
            begin
                group_value_next = '0;
                digit_count_next = '0;
            end
            else
            begin
                group_value_next = sum;
                digit_count_next = taken;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_value_reg <= '0;
            digit_count_reg <= '0;
            emit_valid_reg  <= 1'b0;
        end
        else
        begin
            group_value_reg <= group_value_next;
            digit_count_reg <= digit_count_next;
            emit_valid_reg  <= emit_valid_next;
        end
    end

    // A full group carries no padding and all four bytes; a partial group
    // gets the padding for its missing positions and one byte fewer than
    // its digit count.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            emit_sum_reg  <= sum;
            emit_pad_reg  <= group_full ? '0 : a85d_pkg::pad_sum(taken);
            emit_last_reg <= group_full ? 2'd3 : 2'(taken - 3'd2);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: group queue. Each entry holds one padded 32-bit word and the
    // index of its last byte. The head is serialized most significant first.
    // ------------------------------------------------------------------------
    a85d_pkg::word_t  queue_word_reg [QUEUE_DEPTH];
    logic [1:0]       queue_last_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] queue_cnt_reg;
    logic [CNT_W-1:0] queue_cnt_next;
    logic [1:0]       byte_idx_reg;
    logic [1:0]       byte_idx_next;
    logic             byte_take;
    logic             pop;
    logic [OCC_W-1:0] occupancy;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign byte_take = byte_chan.valid && byte_chan.ready;
    assign pop       = byte_take && (byte_idx_reg == queue_last_reg[rd_ptr_reg]);

    // Every word still on its way to the queue takes one entry, and so does
    // the character in the input register when it closes a group. A new
    // character is taken only while one more entry remains after those.
    assign occupancy       = OCC_W'(queue_cnt_reg) + OCC_W'(emit) +
                             OCC_W'(emit_valid_reg);
    assign char_chan.ready = (occupancy < OCC_W'(QUEUE_DEPTH));

    always_comb
    begin
        queue_cnt_next = queue_cnt_reg;
        if (emit_valid_reg && !pop)
        begin
            queue_cnt_next = queue_cnt_reg + 1'b1;
        end
        else if (!emit_valid_reg && pop)
        begin
            queue_cnt_next = queue_cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        byte_idx_next = byte_idx_reg;
        if (pop)
        begin
            byte_idx_next = '0;
        end
        else if (byte_take)
        begin
            byte_idx_next = byte_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            queue_cnt_reg <= '0;
            byte_idx_reg  <= '0;
        end
        else
        begin
            queue_cnt_reg <= queue_cnt_next;
            byte_idx_reg  <= byte_idx_next;
            if (emit_valid_reg)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    // The padding add sits here, between the accumulator and the queue.
    always_ff @(posedge clk)
    begin
        if (emit_valid_reg)
        begin
            queue_word_reg[wr_ptr_reg] <= emit_sum_reg + emit_pad_reg;
            queue_last_reg[wr_ptr_reg] <= emit_last_reg;
        end
    end

    // Byte selection from the head word, most significant byte first.
    a85d_pkg::word_t head_word;
    assign head_word = queue_word_reg[rd_ptr_reg];

    always_comb
    begin
        unique case (byte_idx_reg)
            2'd0:    byte_chan.out_byte = head_word[31:24];
            2'd1:    byte_chan.out_byte = head_word[23:16];
            2'd2:    byte_chan.out_byte = head_word[15:8];
            default: byte_chan.out_byte = head_word[7:0];
        endcase
    end

    assign byte_chan.valid    = (queue_cnt_reg != '0);
    assign byte_chan.run_last = (byte_idx_reg == queue_last_reg[rd_ptr_reg]);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The queue never overflows its storage.
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("group queue count exceeds its depth");

    // A word never arrives at a full queue: ready reservation must prevent it.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid_reg |-> (queue_cnt_reg < CNT_W'(QUEUE_DEPTH)) || pop)
        else $error("group word pushed into a full queue");

    // The digit count stays within one group.
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg < 3'(a85d_pkg::GROUP_DIGITS))
        else $error("digit count outside of a group");

    // A final character always leaves the accumulator at its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_final_reg) |=> (digit_count_reg == '0) && (group_value_reg == '0))
        else $error("accumulator not cleared after final character");

    // The byte index never runs past the last byte of the head word.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_chan.valid |-> (byte_idx_reg <= queue_last_reg[rd_ptr_reg]))
        else $error("byte index beyond the last byte of the group");

endmodule
